// ===== hdl/dfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dfsc_pkg
// Shared widths, operation codes and request types of the dark and flat
// spectrum correction block.
// ----------------------------------------------------------------------------
package dfsc_pkg;

  localparam int SAMPLES       = 2048;
  localparam int FRACTION_BITS = 12;

  localparam int ADDR_W   = $clog2(SAMPLES);
  localparam int OP_W     = 2;
  localparam int POS_W    = 11;
  localparam int DATA_W   = 16;
  localparam int SAMPLE_W = 18;
  localparam int CORR_W   = 30;
  localparam int NUM_W    = SAMPLE_W + FRACTION_BITS;
  localparam int CORR_MAX = (1 << (CORR_W - 1)) - 1;

  localparam int IN_TDATA_W  = ((POS_W + DATA_W + SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CORR_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_LOAD_DARK   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_BRIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_SUBTRACT    = 2'd2;
  localparam logic [OP_W-1:0] OP_DIVIDE      = 2'd3;

  typedef struct packed {
    logic                     is_div;
    logic                     neg;
    logic                     replaced;
    logic [DATA_W-1:0]        divisor;
    logic signed [CORR_W-1:0] diff;
  } div_side_t;

  typedef struct packed {
    div_side_t        side;
    logic [NUM_W-1:0] num;
  } div_req_t;

endpackage

// ===== hdl/dark_flat_spectrum_correction.sv =====
// ----------------------------------------------------------------------------
// dark_flat_spectrum_correction
// Per-pixel dark subtraction and flat-field division against two reference
// stores held in block RAM.
//
//   channel | ports  | tdata (low bit up)                     | tuser
//   --------+--------+----------------------------------------+--------------
//   input   | in_*   | position, reference_value, sample      | operation
//   result  | out_*  | corrected                              | span_replaced
//
// One request per cycle is accepted while the result side keeps up.
// A read request passes one RAM read register, one divider input register,
// the divider stages, one quotient bit per stage, and one output
// register. Loads finish in their accept cycle and give no result.
// Reset is synchronous and clears only the stage valid bits; the reference
// stores are not cleared. A stalled output backs up stage by stage.
// ----------------------------------------------------------------------------
module dark_flat_spectrum_correction (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // position[10:0], reference_value[26:11], sample[44:27], zero fill
  input  logic [dfsc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // operation[1:0]
  input  logic [dfsc_pkg::OP_W-1:0]            in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // corrected[29:0], zero fill
  output logic [dfsc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // span_replaced
  output logic                                 out_tuser
);

  localparam int POS_W    = dfsc_pkg::POS_W;
  localparam int DATA_W   = dfsc_pkg::DATA_W;
  localparam int SAMPLE_W = dfsc_pkg::SAMPLE_W;
  localparam int ADDR_W   = dfsc_pkg::ADDR_W;
  localparam int NUM_W    = dfsc_pkg::NUM_W;
  localparam int CORR_W   = dfsc_pkg::CORR_W;

  logic [dfsc_pkg::OP_W-1:0] op;
  logic [POS_W-1:0]          position;
  logic [DATA_W-1:0]         reference_value;
  logic signed [SAMPLE_W-1:0] sample;
  logic                      accept;
  logic                      is_read;
  logic                      in_range;
  logic [ADDR_W-1:0]         addr;

  assign op              = in_tuser;
  assign position        = in_tdata[POS_W-1:0];
  assign reference_value = in_tdata[POS_W+DATA_W-1:POS_W];
  assign sample          = $signed(in_tdata[POS_W+DATA_W+SAMPLE_W-1:POS_W+DATA_W]);
  assign accept          = in_tvalid && in_tready;
  assign is_read         = (op == dfsc_pkg::OP_SUBTRACT) || (op == dfsc_pkg::OP_DIVIDE);
  assign in_range        = 32'(position) < dfsc_pkg::SAMPLES;
  assign addr            = ADDR_W'(position);

  logic [DATA_W-1:0] dark_q;
  logic [DATA_W-1:0] bright_q;
  logic              ram_re;

  assign ram_re = accept && is_read;

  dfsc_ram #(.WIDTH(DATA_W), .DEPTH(dfsc_pkg::SAMPLES)) u_dark_ram (
    .clk   (clk),
    .we    (accept && (op == dfsc_pkg::OP_LOAD_DARK) && in_range),
    .waddr (addr),
    .wdata (reference_value),
    .re    (ram_re),
    .raddr (addr),
    .rdata (dark_q)
  );

  dfsc_ram #(.WIDTH(DATA_W), .DEPTH(dfsc_pkg::SAMPLES)) u_bright_ram (
    .clk   (clk),
    .we    (accept && (op == dfsc_pkg::OP_LOAD_BRIGHT) && in_range),
    .waddr (addr),
    .wdata (reference_value),
    .re    (ram_re),
    .raddr (addr),
    .rdata (bright_q)
  );

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  logic                       s1_is_div_r;
  logic                       s1_inside_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       div_in_ready;

  assign in_tready = !s1_valid_r || div_in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = accept && is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (ram_re) begin
      s1_is_div_r <= (op == dfsc_pkg::OP_DIVIDE);
      s1_inside_r <= in_range;
      s1_sample_r <= sample;
    end
  end

  logic [DATA_W-1:0]          dark;
  logic [DATA_W-1:0]          bright;
  logic signed [DATA_W:0]     span;
  logic                       replaced;
  logic [SAMPLE_W-1:0]        smag;
  dfsc_pkg::div_req_t         req;

  always_comb begin
    dark     = s1_inside_r ? dark_q : '0;
    bright   = s1_inside_r ? bright_q : '0;
    span     = $signed({1'b0, bright}) - $signed({1'b0, dark});
    replaced = span[DATA_W] || (span == '0);
    smag     = s1_sample_r[SAMPLE_W-1] ? SAMPLE_W'(-s1_sample_r) : SAMPLE_W'(s1_sample_r);
    req.side.is_div   = s1_is_div_r;
    req.side.neg      = s1_sample_r[SAMPLE_W-1];
    req.side.replaced = replaced;
    req.side.divisor  = replaced ? DATA_W'(1) : span[DATA_W-1:0];
    req.side.diff     = CORR_W'(s1_sample_r) - CORR_W'({1'b0, dark});
    req.num           = NUM_W'(smag) << dfsc_pkg::FRACTION_BITS;
  end

  logic signed [CORR_W-1:0] div_corrected;
  logic                     div_flag;

  dfsc_div u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (s1_valid_r),
    .in_ready      (div_in_ready),
    .in_req        (req),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_corrected (div_corrected),
    .out_flag      (div_flag)
  );

  assign out_tdata = {{(dfsc_pkg::OUT_TDATA_W - CORR_W){1'b0}}, div_corrected};
  assign out_tuser = div_flag;

  a_read_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_read |=> s1_valid_r)
    else $error("accepted read request not held in the RAM stage");

  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !div_in_ready |=> s1_valid_r && $stable(dark_q) && $stable(bright_q)
      && $stable(s1_sample_r))
    else $error("stalled RAM stage lost its read data");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready while the RAM stage is empty");

endmodule

// ===== hdl/dfsc_ram.sv =====
// ----------------------------------------------------------------------------
// dfsc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dfsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dfsc_div.sv =====
// ----------------------------------------------------------------------------
// dfsc_div
// Pipelined restoring divider, one quotient bit per stage, with sign
// restoration, saturation, a pass-through of the difference for subtract requests, and the output register.
// ----------------------------------------------------------------------------
module dfsc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dfsc_pkg::div_req_t                in_req,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dfsc_pkg::CORR_W-1:0] out_corrected,
  output logic                              out_flag
);

  localparam int NUM_W  = dfsc_pkg::NUM_W;
  localparam int DATA_W = dfsc_pkg::DATA_W;
  localparam int CORR_W = dfsc_pkg::CORR_W;
  localparam int WIDE_W = (NUM_W + 1 > CORR_W) ? NUM_W + 1 : CORR_W;
  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(dfsc_pkg::CORR_MAX);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - WIDE_W'(1);

  logic                v_r    [0:NUM_W];
  dfsc_pkg::div_side_t side_r [0:NUM_W];
  logic [DATA_W-1:0]   rem_r  [0:NUM_W];
  logic [NUM_W-1:0]    nq_r   [0:NUM_W];
  logic                rdy    [0:NUM_W+1];

  logic                     out_valid_r;
  logic signed [CORR_W-1:0] out_corrected_r;
  logic                     out_flag_r;

  assign rdy[NUM_W+1] = !out_valid_r || out_ready;
  assign in_ready     = rdy[0];

  genvar k;
  generate
    for (k = 0; k <= NUM_W; k++) begin : g_rdy
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_valid;
    end
    if (rdy[0]) begin
      side_r[0] <= in_req.side;
      rem_r[0]  <= '0;
      nq_r[0]   <= in_req.num;
    end
  end

  generate
    for (k = 0; k < NUM_W; k++) begin : g_stage
      logic [DATA_W:0]   trial;
      logic              fits;
      logic [DATA_W-1:0] rem_nxt;
      logic [NUM_W-1:0]  nq_nxt;

      always_comb begin
        trial   = {rem_r[k], nq_r[k][NUM_W-1]};
        fits    = trial >= {1'b0, side_r[k].divisor};
        rem_nxt = fits ? DATA_W'(trial - {1'b0, side_r[k].divisor}) : trial[DATA_W-1:0];
        nq_nxt  = {nq_r[k][NUM_W-2:0], fits};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k+1] <= 1'b0;
        end else if (rdy[k+1]) begin
          v_r[k+1] <= v_r[k];
        end
        if (rdy[k+1]) begin
          side_r[k+1] <= side_r[k];
          rem_r[k+1]  <= rem_nxt;
          nq_r[k+1]   <= nq_nxt;
        end
      end
    end
  endgenerate

  logic signed [WIDE_W-1:0] quo_w;
  logic signed [WIDE_W-1:0] signed_w;
  logic signed [WIDE_W-1:0] sat_w;
  logic signed [CORR_W-1:0] corrected_nxt;

  always_comb begin
    quo_w    = $signed(WIDE_W'(nq_r[NUM_W]));
    signed_w = side_r[NUM_W].neg ? -quo_w : quo_w;
    if (signed_w > SAT_MAX) begin
      sat_w = SAT_MAX;
    end else if (signed_w < SAT_MIN) begin
      sat_w = SAT_MIN;
    end else begin
      sat_w = signed_w;
    end
    corrected_nxt = side_r[NUM_W].is_div ? CORR_W'(sat_w) : side_r[NUM_W].diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NUM_W+1]) begin
      out_valid_r <= v_r[NUM_W];
    end
    if (rdy[NUM_W+1]) begin
      out_corrected_r <= corrected_nxt;
      out_flag_r      <= side_r[NUM_W].is_div && side_r[NUM_W].replaced;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_corrected = out_corrected_r;
  assign out_flag      = out_flag_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NUM_W] |-> (rem_r[NUM_W] < side_r[NUM_W].divisor))
    else $error("remainder not below divisor at last stage");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NUM_W] && rdy[NUM_W+1] |=> out_valid_r)
    else $error("finished quotient did not reach the output register");

  a_in_to_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && rdy[0] |=> v_r[0])
    else $error("accepted request missing from first stage");

endmodule
